[hdl/tsfs_pkg.sv]
// ----------------------------------------------------------------------------
// tsfs_pkg
// shared widths, character codes and item types of the text symbol scanner
// ----------------------------------------------------------------------------
package tsfs_pkg;

  localparam int unsigned OFFSET_BITS = 24;  // position counter width
  localparam int unsigned POS_W       = OFFSET_BITS;
  localparam int unsigned FIELD_W     = 24;  // offset / length field width
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned BYTE_W      = 8;

  localparam logic [BYTE_W-1:0] CH_UPPER_T = 8'h54;
  localparam logic [BYTE_W-1:0] CH_LOWER_T = 8'h74;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

  localparam logic [FIELD_W-1:0] PLACEHOLDER_LEN = FIELD_W'(3);

  typedef struct packed {
    logic [BYTE_W-1:0] map_byte;
    logic              last_byte;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [ADDR_W-1:0]  symbol_address;
    logic [FIELD_W-1:0] name_offset;
    logic [FIELD_W-1:0] name_length;
  } result_t;

endpackage

[hdl/tsfs_in_stage.sv]
// ----------------------------------------------------------------------------
// tsfs_in_stage
// input register holding one map byte until the scan core consumes it
// ----------------------------------------------------------------------------
module tsfs_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tsfs_pkg::item_t in_item,
  output logic            item_vld,
  output tsfs_pkg::item_t item,
  input  logic            item_take
);

  logic            vld_r;
  logic            vld_nxt;
  tsfs_pkg::item_t item_r;

  // free slot, or the held byte leaves this cycle
  assign in_ready = !vld_r || item_take;
  assign vld_nxt  = (in_valid && in_ready) || (vld_r && !item_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

[hdl/tsfs_scan_core.sv]
// ----------------------------------------------------------------------------
// tsfs_scan_core
// per-byte line parser, best text symbol tracking and query register
// ----------------------------------------------------------------------------
module tsfs_scan_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tsfs_pkg::ADDR_W-1:0]   cfg_query,
  input  logic                          item_vld,
  input  tsfs_pkg::item_t               item,
  input  logic                          res_free,
  output logic                          item_take,
  output logic                          res_load,
  output tsfs_pkg::result_t             res
);

  typedef enum logic [2:0] {
    PH_HEX,
    PH_SEEK,
    PH_TYPE,
    PH_GAP,
    PH_NAME,
    PH_SKIP
  } phase_t;

  phase_t                           phase_r, phase_nxt;
  logic [tsfs_pkg::ADDR_W-1:0]      query_r;
  logic [tsfs_pkg::ADDR_W-1:0]      acc_r, acc_nxt;
  logic [tsfs_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic                             text_r, text_nxt;
  logic [tsfs_pkg::POS_W-1:0]       start_r, start_nxt;
  logic [tsfs_pkg::ADDR_W-1:0]      floor_addr_r, floor_addr_nxt;
  logic [tsfs_pkg::POS_W-1:0]       best_ofs_r, best_ofs_nxt;
  logic [tsfs_pkg::POS_W-1:0]       best_len_r, best_len_nxt;
  logic                             best_found_r, best_found_nxt;

  logic [tsfs_pkg::BYTE_W-1:0]      c;
  logic                             is_nl;
  logic                             is_sp;
  logic [4:0]                       hex;
  logic                             offer_en;
  logic                             offer_text;
  logic [tsfs_pkg::POS_W-1:0]       offer_start;
  logic [tsfs_pkg::POS_W-1:0]       offer_len;
  logic                             take_best;

  // {valid, digit value}
  function automatic logic [4:0] hex_decode(input logic [tsfs_pkg::BYTE_W-1:0] ch);
    logic [4:0] r;
    r = 5'b0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, ch[3:0]};
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      r = {1'b1, ch[3:0] + 4'd9};
    end
    return r;
  endfunction

  // a last byte needs the result register
  assign item_take = item_vld && (!item.last_byte || res_free);
  assign res_load  = item_take && item.last_byte;

  assign c     = item.map_byte;
  assign is_nl = (c == tsfs_pkg::CH_NEWLINE);
  assign is_sp = (c == tsfs_pkg::CH_SPACE);
  assign hex   = hex_decode(c);

  always_comb begin
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    text_nxt       = text_r;
    start_nxt      = start_r;
    pos_nxt        = pos_r + tsfs_pkg::POS_W'(1);
    offer_en       = 1'b0;
    offer_text     = text_r;
    offer_start    = start_r;
    offer_len      = '0;

    case (phase_r)
      PH_HEX: begin
        if (hex[4]) begin
          acc_nxt = {acc_r[tsfs_pkg::ADDR_W-5:0], hex[3:0]};
        end else if (is_sp) begin
          phase_nxt = PH_TYPE;
        end else if (!is_nl) begin
          phase_nxt = PH_SEEK;
        end
      end
      PH_SEEK: begin
        if (is_sp) begin
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (c == tsfs_pkg::CH_UPPER_T || c == tsfs_pkg::CH_LOWER_T) begin
          text_nxt  = 1'b1;
          start_nxt = pos_r + tsfs_pkg::POS_W'(2);
          phase_nxt = PH_GAP;
        end else if (!is_nl) begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_GAP: begin
        if (is_nl) begin
          offer_en = 1'b1;
        end else begin
          phase_nxt = PH_NAME;
        end
      end
      PH_NAME: begin
        if (is_nl) begin
          offer_en  = 1'b1;
          offer_len = pos_r - start_r;
        end
      end
      default: begin
        if (!is_nl) begin
          phase_nxt = PH_SKIP;
        end
      end
    endcase

    // newline starts a fresh line in every phase
    if (is_nl) begin
      phase_nxt = PH_HEX;
      acc_nxt   = '0;
      text_nxt  = 1'b0;
    end

    // map ends inside a text line: offer what has been seen
    if (item.last_byte) begin
      if (phase_nxt == PH_GAP) begin
        offer_en    = 1'b1;
        offer_text  = text_nxt;
        offer_start = start_nxt;
        offer_len   = '0;
      end else if (phase_nxt == PH_NAME) begin
        offer_en    = 1'b1;
        offer_text  = text_nxt;
        offer_start = start_nxt;
        offer_len   = pos_r + tsfs_pkg::POS_W'(1) - start_r;
      end
    end

    // address in the line is unchanged in every offering phase
    take_best = offer_en && offer_text && (acc_r <= query_r) && (acc_r > floor_addr_r);

    floor_addr_nxt = take_best ? acc_r       : floor_addr_r;
    best_ofs_nxt   = take_best ? offer_start : best_ofs_r;
    best_len_nxt   = take_best ? offer_len   : best_len_r;
    best_found_nxt = take_best || best_found_r;
  end

  assign res.found          = best_found_nxt;
  assign res.symbol_address = floor_addr_nxt;
  assign res.name_offset    = tsfs_pkg::FIELD_W'(best_ofs_nxt);
  assign res.name_length    = tsfs_pkg::FIELD_W'(best_len_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r <= '0;
    end else if (cfg_we) begin
      query_r <= cfg_query;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_load) begin
      phase_r      <= PH_HEX;
      acc_r        <= '0;
      pos_r        <= '0;
      text_r       <= 1'b0;
      start_r      <= '0;
      floor_addr_r <= '0;
      best_ofs_r   <= '0;
      best_len_r   <= tsfs_pkg::POS_W'(tsfs_pkg::PLACEHOLDER_LEN);
      best_found_r <= 1'b0;
    end else if (item_take) begin
      phase_r      <= phase_nxt;
      acc_r        <= acc_nxt;
      pos_r        <= pos_nxt;
      text_r       <= text_nxt;
      start_r      <= start_nxt;
      floor_addr_r <= floor_addr_nxt;
      best_ofs_r   <= best_ofs_nxt;
      best_len_r   <= best_len_nxt;
      best_found_r <= best_found_nxt;
    end
  end

endmodule

[hdl/tsfs_out_stage.sv]
// ----------------------------------------------------------------------------
// tsfs_out_stage
// result register holding one scan result until the consumer takes it
// ----------------------------------------------------------------------------
module tsfs_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_load,
  input  tsfs_pkg::result_t res,
  output logic              res_free,
  output logic              out_valid,
  input  logic              out_ready,
  output tsfs_pkg::result_t out_res
);

  logic              vld_r;
  logic              vld_nxt;
  tsfs_pkg::result_t res_r;

  assign res_free = !vld_r || out_ready;
  assign vld_nxt  = res_load || (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

[hdl/text_symbol_floor_scanner.sv]
// ----------------------------------------------------------------------------
// text_symbol_floor_scanner
// scans an nm style symbol map byte by byte and reports the text symbol
// with the highest address above zero and at or below the query address
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  in_      | in        | in_valid/in_ready   | map_byte[7:0], last_byte
//  out_     | out       | out_valid/out_ready | found, symbol_address[63:0],
//           |           |                     | name_offset[23:0], name_length
//  cfg_     | in        | cfg_valid/cfg_ready | query_address[63:0]
//
// one byte per cycle; a request is parsed into the scan state while it sits
// in the input register, and a last byte loads the result register at that
// same edge, so out_valid rises in the cycle after the last byte is taken.
// synchronous reset clears the scan state, the query and both valid flags.
// a last byte waits in the input register while the result register is
// still full; other bytes never stall. cfg_ready is always high.
// ----------------------------------------------------------------------------
module text_symbol_floor_scanner (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tsfs_pkg::BYTE_W-1:0] in_map_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [tsfs_pkg::ADDR_W-1:0]  out_symbol_address,
  output logic [tsfs_pkg::FIELD_W-1:0] out_name_offset,
  output logic [tsfs_pkg::FIELD_W-1:0] out_name_length,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tsfs_pkg::ADDR_W-1:0]  cfg_query_address
);

  tsfs_pkg::item_t   in_item;
  tsfs_pkg::item_t   item;
  logic              item_vld;
  logic              item_take;
  logic              res_load;
  logic              res_free;
  tsfs_pkg::result_t res;
  tsfs_pkg::result_t out_res;

  assign in_item.map_byte  = in_map_byte;
  assign in_item.last_byte = in_last_byte;
  assign cfg_ready         = 1'b1;

  tsfs_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .item_vld  (item_vld),
    .item      (item),
    .item_take (item_take)
  );

  tsfs_scan_core u_scan_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_query (cfg_query_address),
    .item_vld  (item_vld),
    .item      (item),
    .res_free  (res_free),
    .item_take (item_take),
    .res_load  (res_load),
    .res       (res)
  );

  tsfs_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_found          = out_res.found;
  assign out_symbol_address = out_res.symbol_address;
  assign out_name_offset    = out_res.name_offset;
  assign out_name_length    = out_res.name_length;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks the text symbol floor scanner against a cycle-free scan predictor:
// nm style maps with random content, under several query addresses, with
// bursty input, a stalling receiver and a long receiver hold-off
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned BYTE_W  = tsfs_pkg::BYTE_W;
  localparam int unsigned ADDR_W  = tsfs_pkg::ADDR_W;
  localparam int unsigned FIELD_W = tsfs_pkg::FIELD_W;
  localparam int unsigned POS_W   = tsfs_pkg::POS_W;

  localparam logic [BYTE_W-1:0] CH_SPACE   = tsfs_pkg::CH_SPACE;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = tsfs_pkg::CH_NEWLINE;
  localparam logic [BYTE_W-1:0] CH_UPPER_T = tsfs_pkg::CH_UPPER_T;
  localparam logic [BYTE_W-1:0] CH_LOWER_T = tsfs_pkg::CH_LOWER_T;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned PHASE_ITEMS    = 140;

  localparam logic [BYTE_W-1:0] CH_ZERO    = "0";
  localparam logic [BYTE_W-1:0] CH_NINE    = "9";
  localparam logic [BYTE_W-1:0] CH_LOWER_A = "a";
  localparam logic [BYTE_W-1:0] CH_LOWER_F = "f";
  localparam logic [BYTE_W-1:0] CH_UPPER_A = "A";
  localparam logic [BYTE_W-1:0] CH_UPPER_F = "F";

  typedef enum logic [2:0] {
    LN_HEX, LN_SEEK, LN_TYPE, LN_GAP, LN_NAME, LN_SKIP
  } line_state_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [BYTE_W-1:0]  in_map_byte = '0;
  logic               in_last_byte = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_found;
  logic [ADDR_W-1:0]  out_symbol_address;
  logic [FIELD_W-1:0] out_name_offset;
  logic [FIELD_W-1:0] out_name_length;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [ADDR_W-1:0]  cfg_query_address = '0;

  text_symbol_floor_scanner uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_map_byte        (in_map_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_symbol_address (out_symbol_address),
    .out_name_offset    (out_name_offset),
    .out_name_length    (out_name_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_query_address  (cfg_query_address)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tsfs_pkg::item_t   map_bytes_pending[$];
  tsfs_pkg::result_t expected_symbols[$];
  logic [7:0]        scan_text[$];
  int                err_count = 0;
  logic [ADDR_W-1:0] recent_address = '0;

  // scan predictor state
  logic [ADDR_W-1:0]  query_reg = '0;
  line_state_t        ln_state = LN_HEX;
  logic [ADDR_W-1:0]  hex_acc = '0;
  logic [POS_W-1:0]   scan_pos = '0;
  logic               line_text = 1'b0;
  logic [POS_W-1:0]   name_start = '0;
  logic [ADDR_W-1:0]  floor_addr = '0;
  logic [POS_W-1:0]   best_offset = '0;
  logic [POS_W-1:0]   best_length = POS_W'(3);
  logic               best_hit = 1'b0;

  function automatic int hex_digit_value(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic void restart_line();
    ln_state  = LN_HEX;
    hex_acc   = '0;
    line_text = 1'b0;
  endfunction

  function automatic void clear_search();
    restart_line();
    scan_pos    = '0;
    name_start  = '0;
    floor_addr  = '0;
    best_offset = '0;
    best_length = POS_W'(tsfs_pkg::PLACEHOLDER_LEN);
    best_hit    = 1'b0;
  endfunction

  function automatic void consider_symbol(logic [POS_W-1:0] len);
    if (line_text && hex_acc <= query_reg && hex_acc > floor_addr) begin
      floor_addr  = hex_acc;
      best_offset = name_start;
      best_length = len;
      best_hit    = 1'b1;
    end
  endfunction

  function automatic void scan_byte(logic [7:0] c, logic last);
    int                hv;
    logic [POS_W-1:0]  pos;
    tsfs_pkg::result_t res;
    pos = scan_pos;
    hv  = hex_digit_value(c);
    case (ln_state)
      LN_HEX: begin
        if (hv >= 0) hex_acc = {hex_acc[ADDR_W-5:0], 4'(hv)};
        else if (c == CH_SPACE) ln_state = LN_TYPE;
        else if (c == CH_NEWLINE) restart_line();
        else ln_state = LN_SEEK;
      end
      LN_SEEK: begin
        if (c == CH_SPACE) ln_state = LN_TYPE;
        else if (c == CH_NEWLINE) restart_line();
      end
      LN_TYPE: begin
        if (c == CH_UPPER_T || c == CH_LOWER_T) begin
          line_text  = 1'b1;
          name_start = pos + POS_W'(2);
          ln_state   = LN_GAP;
        end else if (c == CH_NEWLINE) begin
          restart_line();
        end else begin
          ln_state = LN_SKIP;
        end
      end
      LN_GAP: begin
        if (c == CH_NEWLINE) begin
          consider_symbol('0);
          restart_line();
        end else begin
          ln_state = LN_NAME;
        end
      end
      LN_NAME: begin
        if (c == CH_NEWLINE) begin
          consider_symbol(pos - name_start);
          restart_line();
        end
      end
      default: begin
        if (c == CH_NEWLINE) restart_line();
        else ln_state = LN_SKIP;
      end
    endcase
    scan_pos = pos + POS_W'(1);
    if (last) begin
      // a map that stops after the type or inside a name still offers that line
      if (ln_state == LN_GAP) consider_symbol('0);
      else if (ln_state == LN_NAME) consider_symbol(pos + POS_W'(1) - name_start);
      res.found          = best_hit;
      res.symbol_address = floor_addr;
      res.name_offset    = FIELD_W'(best_offset);
      res.name_length    = FIELD_W'(best_length);
      expected_symbols.push_back(res);
      clear_search();
    end
  endfunction

  function automatic void check_field(string field, logic [ADDR_W-1:0] want,
                                      logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      err_count++;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 4'd10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(d) - 8'd10;
  endfunction

  function automatic logic [7:0] random_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (hex_digit_value(c) >= 0 || c == CH_SPACE || c == CH_NEWLINE);
    return c;
  endfunction

  function automatic logic [7:0] random_non_newline();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_NEWLINE);
    return c;
  endfunction

  function automatic logic [7:0] random_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_NEWLINE || c == CH_SPACE);
    return c;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address(logic [ADDR_W-1:0] q);
    logic [ADDR_W-1:0] a;
    case ($urandom_range(0, 8))
      0: a = q;
      1: a = q - ADDR_W'($urandom_range(1, 64));
      2: a = q + ADDR_W'($urandom_range(1, 64));
      3: a = '0;
      4: a = {$urandom(), $urandom()};
      5: a = '1;
      6: a = ADDR_W'($urandom_range(1, 255));
      7: a = q >> $urandom_range(1, 63);
      default: a = recent_address;  // repeats give ties
    endcase
    recent_address = a;
    return a;
  endfunction

  function automatic void push_hex(logic [ADDR_W-1:0] value);
    int digits;
    int extra;
    int i;
    logic zeros;
    digits = 16;
    extra  = 0;
    zeros  = 1'b1;
    while (digits > 1 && value[(digits-1)*4 +: 4] == 4'd0) digits--;
    case ($urandom_range(0, 3))
      0: extra = 0;
      1: digits = 16;
      2: extra = $urandom_range(1, 3);
      default: begin
        // leading digits beyond sixteen shift out of the accumulator
        digits = 16;
        extra  = $urandom_range(1, 3);
        zeros  = 1'b0;
      end
    endcase
    repeat (extra) scan_text.push_back(hex_char(zeros ? 4'd0 : 4'($urandom_range(0, 15))));
    for (i = digits - 1; i >= 0; i--) scan_text.push_back(hex_char(value[i*4 +: 4]));
  endfunction

  function automatic void push_name(int len);
    repeat (len) begin
      if ($urandom_range(0, 7) == 0) scan_text.push_back(random_non_newline());
      else scan_text.push_back(8'($urandom_range(33, 126)));
    end
  endfunction

  function automatic void push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) scan_text.push_back(s[i]);
  endfunction

  function automatic void add_text_line(logic [ADDR_W-1:0] q);
    int kind;
    int r;
    kind = $urandom_range(0, 15);
    if (kind < 10) begin
      push_hex(pick_address(q));
      scan_text.push_back(CH_SPACE);
      r = $urandom_range(0, 9);
      if (r < 4) scan_text.push_back(CH_UPPER_T);
      else if (r < 7) scan_text.push_back(CH_LOWER_T);
      else scan_text.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) != 0) begin
        scan_text.push_back($urandom_range(0, 7) != 0 ? CH_SPACE : random_non_newline());
        push_name($urandom_range(0, 12));
      end
      scan_text.push_back(CH_NEWLINE);
    end else begin
      case (kind)
        10: begin  // no space anywhere on the line
          push_hex(pick_address(q));
          repeat ($urandom_range(0, 6)) scan_text.push_back(random_plain());
          scan_text.push_back(CH_NEWLINE);
        end
        11: begin  // junk between the digits and the space
          push_hex(pick_address(q));
          scan_text.push_back(random_non_hex());
          repeat ($urandom_range(0, 3)) scan_text.push_back(random_plain());
          scan_text.push_back(CH_SPACE);
          scan_text.push_back($urandom_range(0, 1) ? CH_UPPER_T : CH_LOWER_T);
          scan_text.push_back(CH_SPACE);
          push_name($urandom_range(1, 8));
          scan_text.push_back(CH_NEWLINE);
        end
        12: begin  // newline in the type position
          push_hex(pick_address(q));
          scan_text.push_back(CH_SPACE);
          scan_text.push_back(CH_NEWLINE);
        end
        13: begin  // newline right after the type
          push_hex(pick_address(q));
          scan_text.push_back(CH_SPACE);
          scan_text.push_back($urandom_range(0, 1) ? CH_UPPER_T : CH_LOWER_T);
          scan_text.push_back(CH_NEWLINE);
        end
        14: begin
          repeat ($urandom_range(1, 12)) scan_text.push_back(8'($urandom_range(0, 255)));
          scan_text.push_back(CH_NEWLINE);
        end
        default: begin  // no address digits at all
          scan_text.push_back(CH_SPACE);
          scan_text.push_back(CH_UPPER_T);
          scan_text.push_back(CH_SPACE);
          push_name($urandom_range(1, 6));
          scan_text.push_back(CH_NEWLINE);
        end
      endcase
    end
  endfunction

  function automatic int queue_map();
    int              n;
    int              i;
    tsfs_pkg::item_t it;
    n = scan_text.size();
    for (i = 0; i < n; i++) begin
      it.map_byte  = scan_text[i];
      it.last_byte = (i == n - 1);
      map_bytes_pending.push_back(it);
    end
    scan_text.delete();
    return n;
  endfunction

  function automatic void queue_random_maps(int min_items);
    int queued;
    int cut;
    queued = 0;
    while (queued < min_items) begin
      if ($urandom_range(0, 9) != 0) repeat ($urandom_range(1, 6)) add_text_line(query_reg);
      if (scan_text.size() > 1 && $urandom_range(0, 2) == 0) begin
        cut = (scan_text.size() > 12) ? 12 : scan_text.size() - 1;
        repeat ($urandom_range(1, cut)) void'(scan_text.pop_back());
      end
      if (scan_text.size() == 0) scan_text.push_back(8'($urandom_range(0, 255)));
      queued += queue_map();
    end
  endfunction

  // ----------------------------------------------------------- driver side

  logic in_taken = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;

  always @(negedge clk) begin
    tsfs_pkg::item_t next;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (map_bytes_pending.size() != 0) begin
        next = map_bytes_pending.pop_front();
        in_valid     <= 1'b1;
        in_map_byte  <= next.map_byte;
        in_last_byte <= next.last_byte;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  logic        hold_off_request = 1'b0;
  int          hold_left = 0;
  int          pattern_age = 0;
  logic [15:0] stall_pattern = '1;

  always @(negedge clk) begin
    if (hold_off_request) begin
      hold_off_request = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        pattern_age   = 48;
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h1);
      end
      pattern_age--;
      out_ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  // ---------------------------------------------------------- monitor side

  always @(posedge clk) begin
    tsfs_pkg::result_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_symbols.size() == 0) begin
          $display("%0t: result with nothing expected, actual %b %h %h %h", $time,
                   out_found, out_symbol_address, out_name_offset, out_name_length);
          err_count++;
        end else begin
          want = expected_symbols.pop_front();
          check_field("found", ADDR_W'(want.found), ADDR_W'(out_found));
          check_field("symbol_address", want.symbol_address, out_symbol_address);
          check_field("name_offset", ADDR_W'(want.name_offset), ADDR_W'(out_name_offset));
          check_field("name_length", ADDR_W'(want.name_length), ADDR_W'(out_name_length));
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        scan_byte(in_map_byte, in_last_byte);
      end
    end
  end

  initial begin
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  // ------------------------------------------------------------- sequencing

  task automatic write_query(logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_query_address <= value;
    do @(posedge clk); while (!cfg_ready);
    query_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (map_bytes_pending.size() != 0 || in_valid || expected_symbols.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [ADDR_W-1:0] queries[6];
    int p;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed maps: empty, hit, equal with bare type, end on type, end on gap, no symbol
    write_query(ADDR_W'(64'h40));
    push_text("\n");       void'(queue_map());
    push_text("3f T ab\n"); void'(queue_map());
    push_text("40 t\n");   void'(queue_map());
    push_text("3 T");      void'(queue_map());
    push_text("2 T ");     void'(queue_map());
    push_text("zz\n");     void'(queue_map());
    wait_drained();

    queries[0] = '1;
    queries[1] = '0;
    queries[2] = {$urandom(), $urandom()};
    queries[3] = ADDR_W'($urandom_range(256, 4096));
    queries[4] = 64'h8000_0000_0000_0000;
    queries[5] = {$urandom(), $urandom()};
    for (p = 0; p < 6; p++) begin
      write_query(queries[p]);
      // receiver holds off while the sender keeps offering bytes
      if (p == 2) hold_off_request = 1'b1;
      queue_random_maps(PHASE_ITEMS);
      wait_drained();
    end

    if (expected_symbols.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_symbols.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[text_symbol_floor_scanner.f]
hdl/tsfs_pkg.sv
hdl/tsfs_in_stage.sv
hdl/tsfs_scan_core.sv
hdl/tsfs_out_stage.sv
hdl/text_symbol_floor_scanner.sv
tb/testbench.sv
